>>> rtl/mi_pkg.sv
// ----------------------------------------------------------------------------
// mi_pkg
// Shared constants and types for the modular inverse unit.
// ----------------------------------------------------------------------------
package mi_pkg;

  // default operand and modulus width
  localparam int unsigned VALUE_BITS_DEF = 31;

  // modulus after reset, cut to the operand width where it is used
  localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

  // core status seen by the top level
  typedef struct packed {
    logic busy;  // an item is at work, no new item taken
    logic done;  // result is held and waits for the output register
  } mi_status_t;

endpackage

>>> rtl/mi_core.sv
// ----------------------------------------------------------------------------
// mi_core
// Extended Euclid sequencer: one shared subtract/compare unit does the
// shift-and-subtract division of each step; a separate subtractor does the coefficient update.
// ----------------------------------------------------------------------------
module mi_core #(
  parameter int unsigned VALUE_BITS = mi_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [VALUE_BITS-1:0] modulus_i,
  input  logic                  ack_i,
  output mi_pkg::mi_status_t    status_o,
  output logic [VALUE_BITS-1:0] inverse_o,
  output logic [VALUE_BITS-1:0] common_divisor_o
);

  // coefficients stay within twice the modulus in magnitude
  localparam int unsigned SW = VALUE_BITS + 3;
  localparam int unsigned KW = $clog2(VALUE_BITS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_ALIGN = 3'd2;
  localparam logic [2:0] ST_SUB   = 3'd3;
  localparam logic [2:0] ST_NORM  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_q, state_d;

  logic [VALUE_BITS-1:0] r0_q, r0_d, r1_q, r1_d, rem_q, rem_d, dv_q, dv_d;
  logic [VALUE_BITS-1:0] mod_q, mod_d, inv_q, inv_d;
  logic signed [SW-1:0]  s0_q, s0_d, s1_q, s1_d, sacc_q, sacc_d, sdv_q, sdv_d;
  logic [KW-1:0]         k_q, k_d;

  // shared remainder unit: compares in align, subtracts in sub
  logic [VALUE_BITS:0]   sub_b;
  logic [VALUE_BITS+1:0] sub_diff;
  logic                  sub_ok;
  logic signed [SW-1:0]  sacc_sub;

  // final normalization terms
  logic signed [SW-1:0]  mod_ext, x_plus, x_minus;

  assign sub_b    = (state_q == ST_ALIGN) ? {dv_q, 1'b0} : {1'b0, dv_q};
  assign sub_diff = {2'b00, rem_q} - {1'b0, sub_b};
  assign sub_ok   = ~sub_diff[VALUE_BITS+1];
  assign sacc_sub = sacc_q - sdv_q;

  assign mod_ext  = $signed({{(SW-VALUE_BITS){1'b0}}, mod_q});
  assign x_plus   = s0_q + mod_ext;
  assign x_minus  = s0_q - mod_ext;

  // sequencer
  always_comb begin
    state_d = state_q;
    r0_d    = r0_q;
    r1_d    = r1_q;
    s0_d    = s0_q;
    s1_d    = s1_q;
    rem_d   = rem_q;
    sacc_d  = sacc_q;
    dv_d    = dv_q;
    sdv_d   = sdv_q;
    k_d     = k_q;
    mod_d   = mod_q;
    inv_d   = inv_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          r0_d    = value_i;
          r1_d    = modulus_i;
          mod_d   = modulus_i;
          s0_d    = SW'(1);
          s1_d    = '0;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (r1_q == '0) begin
          state_d = ST_NORM;
        end else begin
          rem_d   = r0_q;
          sacc_d  = s0_q;
          dv_d    = r1_q;
          sdv_d   = s1_q;
          k_d     = '0;
          state_d = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        // double the divisor while it still fits under the remainder
        if (sub_ok) begin
          dv_d  = sub_b[VALUE_BITS-1:0];
          sdv_d = sdv_q <<< 1;
          k_d   = k_q + KW'(1);
        end else begin
          state_d = ST_SUB;
        end
      end
      ST_SUB: begin
        if (sub_ok) begin
          rem_d  = sub_diff[VALUE_BITS-1:0];
          sacc_d = sacc_sub;
        end
        if (k_q == '0) begin
          // step complete: shift the remainder and coefficient pairs
          r0_d    = r1_q;
          r1_d    = sub_ok ? sub_diff[VALUE_BITS-1:0] : rem_q;
          s0_d    = s1_q;
          s1_d    = sub_ok ? sacc_sub : sacc_q;
          state_d = ST_CHECK;
        end else begin
          dv_d = dv_q >> 1;
          sdv_d = sdv_q >>> 1;
          k_d  = k_q - KW'(1);
        end
      end
      ST_NORM: begin
        // bring the coefficient into [0, modulus); a zero modulus gives zero
        if (mod_q == '0) begin
          inv_d = '0;
        end else if (s0_q[SW-1]) begin
          inv_d = x_plus[VALUE_BITS-1:0];
        end else if (!x_minus[SW-1]) begin
          inv_d = x_minus[VALUE_BITS-1:0];
        end else begin
          inv_d = s0_q[VALUE_BITS-1:0];
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    r0_q   <= r0_d;
    r1_q   <= r1_d;
    s0_q   <= s0_d;
    s1_q   <= s1_d;
    rem_q  <= rem_d;
    sacc_q <= sacc_d;
    dv_q   <= dv_d;
    sdv_q  <= sdv_d;
    k_q    <= k_d;
    mod_q  <= mod_d;
    inv_q  <= inv_d;
  end

  assign status_o.busy    = (state_q != ST_IDLE);
  assign status_o.done    = (state_q == ST_DONE);
  assign inverse_o        = inv_q;
  assign common_divisor_o = r0_q;

  // checks
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == ST_IDLE)
    else $error("start while core busy");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ALIGN || state_q == ST_SUB) |-> dv_q != '0)
    else $error("zero divisor in division");

  a_rem_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUB && k_q == '0) |=> r1_q < r0_q)
    else $error("remainder not below divisor after step");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !ack_i) |=> state_q == ST_DONE && $stable(inv_q))
    else $error("result dropped before it was taken");

endmodule

>>> rtl/modular_inverse_unit.sv
// Modular inverse unit: takes one operand and returns its inverse modulo the
// configured modulus together with gcd(value, modulus); the inverse is
// meaningful only when the divisor is 1. One item is worked on at a time by
// an extended Euclid sequencer with a single shift-and-subtract unit. Each
// Euclid step first aligns the divisor by doubling it, then subtracts it
// while halving it back down; each item also passes through start,
// normalization and hand-off. Consecutive Fibonacci numbers give the longest
// Euclid chains. The input stalls while an item is at work, until its result
// has been taken by the output register. The output register lets a finished
// result wait while the next item is taken.
// ----------------------------------------------------------------------------
// modular_inverse_unit
// Top level: modulus register, input handshake, core and output register.
// ----------------------------------------------------------------------------
module modular_inverse_unit #(
  parameter int unsigned VALUE_BITS = mi_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [VALUE_BITS-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VALUE_BITS-1:0] inverse_o,
  output logic [VALUE_BITS-1:0] common_divisor_o
);

  localparam logic [VALUE_BITS-1:0] ModRst = mi_pkg::MODULUS_RESET[VALUE_BITS-1:0];

  logic [VALUE_BITS-1:0] modulus_q;
  logic                  out_valid_q;
  logic [VALUE_BITS-1:0] inverse_q, gcd_q;

  mi_pkg::mi_status_t    core_status;
  logic [VALUE_BITS-1:0] core_inverse, core_gcd;
  logic                  in_take, out_free, core_ack;

  assign in_stall_o = core_status.busy;
  assign in_take    = in_valid_i & ~core_status.busy;
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign core_ack   = core_status.done & out_free;

  // modulus register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModRst;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_data_i;
    end
  end

  mi_core #(
    .VALUE_BITS(VALUE_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (in_take),
    .value_i         (value_i),
    .modulus_i       (modulus_q),
    .ack_i           (core_ack),
    .status_o        (core_status),
    .inverse_o       (core_inverse),
    .common_divisor_o(core_gcd)
  );

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= core_status.done;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (core_ack) begin
      inverse_q <= core_inverse;
      gcd_q     <= core_gcd;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign inverse_o        = inverse_q;
  assign common_divisor_o = gcd_q;

endmodule

>>> tb/modular_inverse_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_inverse_unit_tb
// Self-checking bench for the modular inverse unit. Operands are pushed through
// the valid/stall input under random gaps. Every accepted operand is run
// through a local extended Euclid model against the modulus in force, and each
// result is checked field by field in order. The modulus is changed between
// phases while the unit is empty, covering zero, one, two, powers of two,
// the largest value, Fibonacci worst cases and random moduli.
// ----------------------------------------------------------------------------
module modular_inverse_unit_tb;

  localparam int unsigned W           = mi_pkg::VALUE_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned DRAIN_TAIL  = 400;

  typedef struct {
    logic [W-1:0] operand;
    logic [W-1:0] modulus;
    logic [W-1:0] inverse;
    logic [W-1:0] divisor;
  } inverse_exp_t;

  logic         clk_i       = 1'b0;
  logic         rst_ni      = 1'b0;
  logic         cfg_we_i    = 1'b0;
  logic [W-1:0] cfg_data_i  = '0;
  logic         in_valid_i  = 1'b0;
  logic         in_stall_o;
  logic [W-1:0] value_i     = '0;
  logic         out_valid_o;
  logic         out_stall_i;
  logic [W-1:0] inverse_o;
  logic [W-1:0] common_divisor_o;

  // bench state
  logic [W-1:0]   operand_q[$];
  inverse_exp_t   inverse_q[$];
  logic [W-1:0]   modulus_cfg   = W'(mi_pkg::MODULUS_RESET);
  int unsigned    items_issued  = 0;
  int unsigned    items_accepted = 0;
  int unsigned    results_seen  = 0;
  int unsigned    mismatches    = 0;
  int unsigned    cycle_cnt     = 0;
  int unsigned    tx_gap        = 0;
  bit             tx_burst      = 1'b0;
  logic           tx_valid_next;
  int unsigned    rx_wait       = 0;
  bit             rx_burst      = 1'b0;
  logic           rx_wait_stall = 1'b0;
  logic           hold_on       = 1'b0;
  int unsigned    hold_left     = 0;
  int unsigned    hold_count    = 0;

  assign out_stall_i = rx_wait_stall | hold_on;

  modular_inverse_unit #(
    .VALUE_BITS(W)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .inverse_o       (inverse_o),
    .common_divisor_o(common_divisor_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // extended euclid, operand coefficient only, arithmetic mod 2^64
  function automatic inverse_exp_t euclid_inverse(input logic [W-1:0] val,
                                                  input logic [W-1:0] m);
    inverse_exp_t r;
    bit [63:0] r0, r1, s0, s1, q, rn, sn, norm;
    r0 = 64'(val);
    r1 = 64'(m);
    s0 = 64'd1;
    s1 = 64'd0;
    while (r1 != 64'd0) begin
      q  = r0 / r1;
      rn = r0 - q * r1;
      sn = s0 - q * s1;
      r0 = r1;
      r1 = rn;
      s0 = s1;
      s1 = sn;
    end
    // zero modulus pins the inverse to zero
    if (m == '0) norm = 64'd0;
    else norm = (64'(m) + s0) % 64'(m);
    r.operand = val;
    r.modulus = m;
    r.inverse = norm[W-1:0];
    r.divisor = r0[W-1:0];
    return r;
  endfunction

  // operand mix: mostly in range, plus zero, near-modulus, shared factors
  function automatic logic [W-1:0] draw_operand(input logic [W-1:0] m);
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick < 9 && m >= 2) return W'($urandom_range(1, m - 1));
    case (pick)
      11: return W'($urandom_range(0, 3));
      12: return W'(m + $urandom_range(0, 3));
      13: return W'($urandom_range(1, 65535) * $urandom_range(2, 12));
      14: return W'(m - 1);
      15: return W'($urandom) >> $urandom_range(0, W - 1);
      default: return W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_result(input logic [W-1:0] inv, input logic [W-1:0] div);
    inverse_exp_t exp_r;
    if (inverse_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: inverse=%0d gcd=%0d",
                                inv, div));
      return;
    end
    exp_r = inverse_q.pop_front();
    if (inv !== exp_r.inverse)
      report_mismatch($sformatf("value=%0d mod=%0d: inverse %0d, want %0d",
                                exp_r.operand, exp_r.modulus, inv, exp_r.inverse));
    if (div !== exp_r.divisor)
      report_mismatch($sformatf("value=%0d mod=%0d: gcd %0d, want %0d",
                                exp_r.operand, exp_r.modulus, div, exp_r.divisor));
  endtask

  task automatic queue_random_operands(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) operand_q.push_back(draw_operand(modulus_cfg));
  endtask

  // idle: nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    while (operand_q.size() != 0 || items_issued != items_accepted ||
           inverse_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic set_modulus(input logic [W-1:0] m);
    wait_idle();
    repeat (4) @(posedge clk_i);
    cfg_data_i  <= m;
    cfg_we_i    <= 1'b1;
    modulus_cfg = m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // input driver: predicts on acceptance, then offers the next queued item
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap = 0;
    end else begin
      tx_valid_next = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        inverse_q.push_back(euclid_inverse(value_i, modulus_cfg));
        items_accepted++;
        tx_valid_next = 1'b0;
      end
      if (!tx_valid_next) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (operand_q.size() != 0) begin
          value_i <= operand_q.pop_front();
          items_issued++;
          tx_valid_next = 1'b1;
          if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 16);
        end
      end
      in_valid_i <= tx_valid_next;
    end
  end

  // output monitor with per-item stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_wait_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_result(inverse_o, common_divisor_o);
        results_seen++;
        if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 16);
      end else if (out_valid_o && rx_wait > 0) begin
        rx_wait--;
      end
      rx_wait_stall <= (rx_wait > 0);
    end
  end

  // long receiver hold-off so the unit fills and stalls its input
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_on <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_count < 2 && results_seen >= 40 + 400 * hold_count &&
                   operand_q.size() > 20) begin
        hold_left = HOLD_CYCLES;
        hold_count++;
      end
      hold_on <= (hold_left > 0);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      report_mismatch($sformatf("timeout after %0d cycles, %0d results seen",
                                cycle_cnt, results_seen));
      $display("Mismatches found");
      $finish;
    end
  end

  // reset and phases
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset modulus: edges, inverse of two, operand equal to and above modulus
    operand_q.push_back(W'(0));
    operand_q.push_back(W'(1));
    operand_q.push_back(W'(2));
    operand_q.push_back(W'(500000004));
    operand_q.push_back(W'(1000000006));
    operand_q.push_back(W'(1000000007));
    operand_q.push_back(W'(1000000008));
    operand_q.push_back(31'h7FFF_FFFF);
    operand_q.push_back(31'h1555_5555);
    operand_q.push_back(31'h2AAA_AAAA);
    queue_random_operands(250);

    // largest modulus
    set_modulus(31'h7FFF_FFFF);
    operand_q.push_back(W'(1));
    operand_q.push_back(31'h7FFF_FFFE);
    operand_q.push_back(31'h4000_0000);
    operand_q.push_back(31'h7FFF_FFFF);
    queue_random_operands(250);

    // zero modulus
    set_modulus('0);
    operand_q.push_back(W'(0));
    operand_q.push_back(W'(5));
    operand_q.push_back(31'h7FFF_FFFF);
    queue_random_operands(20);

    // modulus one
    set_modulus(W'(1));
    operand_q.push_back(W'(0));
    operand_q.push_back(W'(1));
    operand_q.push_back(31'h7FFF_FFFF);
    queue_random_operands(20);

    set_modulus(W'(2));
    queue_random_operands(30);

    // power of two: even operands have no inverse
    set_modulus(31'h4000_0000);
    operand_q.push_back(W'(1));
    operand_q.push_back(W'(2));
    operand_q.push_back(W'(3));
    operand_q.push_back(31'h4000_0000);
    queue_random_operands(150);

    // consecutive fibonacci numbers give the longest euclid chain
    set_modulus(W'(1836311903));
    operand_q.push_back(W'(1134903170));
    queue_random_operands(30);

    for (int p = 0; p < 4; p++) begin
      set_modulus(W'($urandom));
      queue_random_operands(150);
    end

    set_modulus(W'($urandom_range(3, 1000)));
    queue_random_operands(100);

    set_modulus(W'(1000000007));
    queue_random_operands(100);

    wait_idle();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (inverse_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", inverse_q.size()));

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
rtl/mi_pkg.sv
rtl/mi_core.sv
rtl/modular_inverse_unit.sv
tb/modular_inverse_unit_tb.sv
